[src/lrbs_pkg.sv]
// Shared types, register codes, reset values and decode functions for the link supervisor.
package lrbs_pkg;

    typedef enum logic [2:0] {
        CMD_CONNECT      = 3'd0,
        CMD_DISCONNECT   = 3'd1,
        CMD_LINK_UP      = 3'd2,
        CMD_LINK_DOWN    = 3'd3,
        CMD_GOT_ADDR     = 3'd4,
        CMD_ADDR_TIMEOUT = 3'd5,
        CMD_RETRY_DUE    = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_IN_PROGRESS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        NTF_NONE         = 2'd0,
        NTF_CONNECTED    = 2'd1,
        NTF_DISCONNECTED = 2'd2,
        NTF_GOT_ADDR     = 2'd3
    } notify_t;

    typedef enum logic [3:0] {
        CLS_AUTH      = 4'd0,
        CLS_NO_AP     = 4'd1,
        CLS_ASSOC     = 4'd2,
        CLS_AP_LEFT   = 4'd3,
        CLS_LOST      = 4'd4,
        CLS_HANDSHAKE = 4'd5,
        CLS_ADDR_FAIL = 4'd6,
        CLS_USER      = 4'd7,
        CLS_UNKNOWN   = 4'd8
    } reason_t;

    typedef enum logic [1:0] {
        PH_DOWN       = 2'd0,
        PH_CONNECTING = 2'd1,
        PH_CONNECTED  = 2'd2,
        PH_GOT_ADDR   = 2'd3
    } phase_t;

    // configuration register indexes
    localparam logic [2:0] REG_LINK_ENABLED     = 3'd0;
    localparam logic [2:0] REG_INITIAL_RETRY_MS = 3'd1;
    localparam logic [2:0] REG_MAX_RETRY_MS     = 3'd2;
    localparam logic [2:0] REG_MAX_RETRIES      = 3'd3;
    localparam logic [2:0] REG_ADDR_TIMEOUT_MS  = 3'd4;

    localparam logic        RST_LINK_ENABLED     = 1'b1;
    localparam logic [31:0] RST_INITIAL_RETRY_MS = 32'd1000;
    localparam logic [31:0] RST_MAX_RETRY_MS     = 32'd30000;
    localparam logic [7:0]  RST_MAX_RETRIES      = 8'd5;
    localparam logic [31:0] RST_ADDR_TIMEOUT_MS  = 32'd10000;

    // driver reason code to class
    function automatic reason_t classify(input logic [7:0] code);
        reason_t cls;
        unique case (code) inside
            8'd2, 8'd6, 8'd202:                cls = CLS_AUTH;
            8'd201, 8'd210, 8'd211, 8'd212:    cls = CLS_NO_AP;
            8'd4, 8'd5, 8'd7, 8'd9:            cls = CLS_ASSOC;
            8'd8, 8'd206:                      cls = CLS_AP_LEFT;
            8'd200, 8'd208:                    cls = CLS_LOST;
            8'd14, 8'd15, 8'd16, 8'd17, 8'd204: cls = CLS_HANDSHAKE;
            default:                           cls = CLS_UNKNOWN;
        endcase
        return cls;
    endfunction

    function automatic logic retriable(input reason_t cls);
        logic r;
        case (cls) inside
            CLS_AP_LEFT, CLS_LOST, CLS_HANDSHAKE, CLS_UNKNOWN, CLS_NO_AP: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // min(first * 2^attempt, cap), with the product taken unbounded
    function automatic logic [31:0] backoff(input logic [31:0] first,
                                            input logic [31:0] cap,
                                            input logic [7:0]  attempt);
        logic [63:0] wide;
        logic [31:0] r;
        wide = {32'd0, first} << attempt[4:0];
        if (attempt[7:5] != 3'd0 && first != 32'd0) begin
            r = cap;
        end else if (wide[63:32] != 32'd0) begin
            r = cap;
        end else if (wide[31:0] > cap) begin
            r = cap;
        end else begin
            r = wide[31:0];
        end
        return r;
    endfunction

endpackage

[src/link_reconnect_backoff_supervisor.sv]
// Link reconnect supervisor: event decode, backoff, state and one result register.
// The result of an accepted event is on the output register in the next cycle.
// Throughput: one event per cycle; the result register is the only stage, and an
// event is taken whenever that register is empty or is being emptied.
// Reset (rst_n low, asynchronous): link down, retry count and flags cleared, output
// empty, configuration registers back to 1 / 1000 / 30000 / 5 / 10000.
module link_reconnect_backoff_supervisor (
    input  logic        clk,
    input  logic        rst_n,
    // event request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [7:0]  reason_code,
    input  logic        start_refused,
    input  logic [31:0] addr_value,
    // result request channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  call_status,
    output logic        start_link,
    output logic        drop_link,
    output logic        arm_retry,
    output logic        arm_addr_timer,
    output logic        cancel_retry,
    output logic        cancel_addr_timer,
    output logic [31:0] timer_ms,
    output logic [1:0]  notify,
    output logic [3:0]  reason_class,
    output logic [1:0]  link_state,
    output logic [31:0] addr_out,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // ---------------- configuration registers ----------------
    logic        link_enabled_reg;
    logic [31:0] initial_retry_ms_reg;
    logic [31:0] max_retry_ms_reg;
    logic [7:0]  max_retries_reg;
    logic [31:0] addr_timeout_ms_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_enabled_reg     <= lrbs_pkg::RST_LINK_ENABLED;
            initial_retry_ms_reg <= lrbs_pkg::RST_INITIAL_RETRY_MS;
            max_retry_ms_reg     <= lrbs_pkg::RST_MAX_RETRY_MS;
            max_retries_reg      <= lrbs_pkg::RST_MAX_RETRIES;
            addr_timeout_ms_reg  <= lrbs_pkg::RST_ADDR_TIMEOUT_MS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lrbs_pkg::REG_LINK_ENABLED:     link_enabled_reg     <= cfg_data[0];
                lrbs_pkg::REG_INITIAL_RETRY_MS: initial_retry_ms_reg <= cfg_data;
                lrbs_pkg::REG_MAX_RETRY_MS:     max_retry_ms_reg     <= cfg_data;
                lrbs_pkg::REG_MAX_RETRIES:      max_retries_reg      <= cfg_data[7:0];
                lrbs_pkg::REG_ADDR_TIMEOUT_MS:  addr_timeout_ms_reg  <= cfg_data;
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // ---------------- supervisor state ----------------
    lrbs_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       retry_count_reg, retry_count_next;
    logic             has_target_reg, has_target_next;
    logic             user_dropped_reg, user_dropped_next;
    logic             swallow_echo_reg, swallow_echo_next;

    // result fields for the event at the input
    lrbs_pkg::status_t r_status;
    logic              r_start, r_drop, r_arm_retry, r_arm_addr;
    logic              r_cancel_retry, r_cancel_addr;
    logic [31:0]       r_timer;
    lrbs_pkg::notify_t r_notify;
    lrbs_pkg::reason_t r_class;
    logic [31:0]       r_addr;

    // output register
    logic              out_valid_reg;
    lrbs_pkg::status_t status_reg;
    logic              start_reg, drop_reg, arm_retry_reg, arm_addr_reg;
    logic              cancel_retry_reg, cancel_addr_reg;
    logic [31:0]       timer_reg;
    lrbs_pkg::notify_t notify_reg;
    lrbs_pkg::reason_t class_reg;
    lrbs_pkg::phase_t  state_reg;
    logic [31:0]       addr_reg;

    logic accept;

    // take a new event whenever the result slot is free or draining this cycle
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    lrbs_pkg::reason_t down_class;
    logic              retry_ok;
    logic [31:0]       backoff_ms;

    assign down_class = lrbs_pkg::classify(reason_code);
    assign retry_ok   = lrbs_pkg::retriable(down_class) && has_target_reg &&
                        (max_retries_reg != 8'd0) && (retry_count_reg < max_retries_reg);
    assign backoff_ms = lrbs_pkg::backoff(initial_retry_ms_reg, max_retry_ms_reg,
                                          retry_count_reg);

    always_comb
    begin
        phase_next        = phase_reg;
        retry_count_next  = retry_count_reg;
        has_target_next   = has_target_reg;
        user_dropped_next = user_dropped_reg;
        swallow_echo_next = swallow_echo_reg;

        r_status       = lrbs_pkg::ST_OK;
        r_start        = 1'b0;
        r_drop         = 1'b0;
        r_arm_retry    = 1'b0;
        r_arm_addr     = 1'b0;
        r_cancel_retry = 1'b0;
        r_cancel_addr  = 1'b0;
        r_timer        = 32'd0;
        r_notify       = lrbs_pkg::NTF_NONE;
        r_class        = lrbs_pkg::CLS_AUTH;
        r_addr         = 32'd0;

        case (lrbs_pkg::cmd_t'(cmd))
            lrbs_pkg::CMD_CONNECT:
            begin
                if (!link_enabled_reg)
                begin
                    r_status = lrbs_pkg::ST_INVALID;
                end
                else if (phase_reg == lrbs_pkg::PH_CONNECTING)
                begin
                    r_status = lrbs_pkg::ST_IN_PROGRESS;
                end
                else
                begin
                    has_target_next   = 1'b1;
                    retry_count_next  = 8'd0;
                    user_dropped_next = 1'b0;
                    phase_next        = lrbs_pkg::PH_CONNECTING;
                    r_start           = 1'b1;
                    if (start_refused)
                    begin
                        // refused start fails fast
                        phase_next = lrbs_pkg::PH_DOWN;
                        r_notify   = lrbs_pkg::NTF_DISCONNECTED;
                        r_class    = lrbs_pkg::CLS_UNKNOWN;
                    end
                end
            end
            lrbs_pkg::CMD_DISCONNECT:
            begin
                user_dropped_next = 1'b1;
                r_cancel_retry    = 1'b1;
                r_cancel_addr     = 1'b1;
                phase_next        = lrbs_pkg::PH_DOWN;
                retry_count_next  = 8'd0;
                if (phase_reg != lrbs_pkg::PH_DOWN)
                begin
                    r_drop   = 1'b1;
                    r_notify = lrbs_pkg::NTF_DISCONNECTED;
                    r_class  = lrbs_pkg::CLS_USER;
                end
            end
            lrbs_pkg::CMD_LINK_UP:
            begin
                phase_next = lrbs_pkg::PH_CONNECTED;
                r_arm_addr = 1'b1;
                r_timer    = addr_timeout_ms_reg;
                r_notify   = lrbs_pkg::NTF_CONNECTED;
            end
            lrbs_pkg::CMD_LINK_DOWN:
            begin
                if (swallow_echo_reg)
                begin
                    // echo of our own drop after an address timeout
                    swallow_echo_next = 1'b0;
                end
                else if (user_dropped_reg)
                begin
                    r_cancel_addr     = 1'b1;
                    user_dropped_next = 1'b0;
                    phase_next        = lrbs_pkg::PH_DOWN;
                end
                else if (retry_ok)
                begin
                    r_cancel_addr    = 1'b1;
                    r_arm_retry      = 1'b1;
                    r_timer          = backoff_ms;
                    retry_count_next = retry_count_reg + 8'd1;
                    phase_next       = lrbs_pkg::PH_CONNECTING;
                end
                else
                begin
                    r_cancel_addr    = 1'b1;
                    phase_next       = lrbs_pkg::PH_DOWN;
                    retry_count_next = 8'd0;
                    r_notify         = lrbs_pkg::NTF_DISCONNECTED;
                    r_class          = down_class;
                end
            end
            lrbs_pkg::CMD_GOT_ADDR:
            begin
                r_cancel_addr    = 1'b1;
                phase_next       = lrbs_pkg::PH_GOT_ADDR;
                retry_count_next = 8'd0;
                r_notify         = lrbs_pkg::NTF_GOT_ADDR;
                r_addr           = addr_value;
            end
            lrbs_pkg::CMD_ADDR_TIMEOUT:
            begin
                if (phase_reg == lrbs_pkg::PH_CONNECTED)
                begin
                    swallow_echo_next = 1'b1;
                    r_drop            = 1'b1;
                    phase_next        = lrbs_pkg::PH_DOWN;
                    retry_count_next  = 8'd0;
                    r_notify          = lrbs_pkg::NTF_DISCONNECTED;
                    r_class           = lrbs_pkg::CLS_ADDR_FAIL;
                end
            end
            lrbs_pkg::CMD_RETRY_DUE:
            begin
                if (!user_dropped_reg && phase_reg == lrbs_pkg::PH_CONNECTING)
                begin
                    r_start = 1'b1;
                    if (start_refused)
                    begin
                        phase_next       = lrbs_pkg::PH_DOWN;
                        retry_count_next = 8'd0;
                        r_notify         = lrbs_pkg::NTF_DISCONNECTED;
                        r_class          = lrbs_pkg::CLS_UNKNOWN;
                    end
                end
            end
            default: ;  // unused code: state holds, result carries only the phase
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lrbs_pkg::PH_DOWN;
            retry_count_reg  <= 8'd0;
            has_target_reg   <= 1'b0;
            user_dropped_reg <= 1'b0;
            swallow_echo_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                retry_count_reg  <= retry_count_next;
                has_target_reg   <= has_target_next;
                user_dropped_reg <= user_dropped_next;
                swallow_echo_reg <= swallow_echo_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted event
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg       <= r_status;
            start_reg        <= r_start;
            drop_reg         <= r_drop;
            arm_retry_reg    <= r_arm_retry;
            arm_addr_reg     <= r_arm_addr;
            cancel_retry_reg <= r_cancel_retry;
            cancel_addr_reg  <= r_cancel_addr;
            timer_reg        <= r_timer;
            notify_reg       <= r_notify;
            class_reg        <= r_class;
            state_reg        <= phase_next;
            addr_reg         <= r_addr;
        end
    end

    assign out_valid         = out_valid_reg;
    assign call_status       = status_reg;
    assign start_link        = start_reg;
    assign drop_link         = drop_reg;
    assign arm_retry         = arm_retry_reg;
    assign arm_addr_timer    = arm_addr_reg;
    assign cancel_retry      = cancel_retry_reg;
    assign cancel_addr_timer = cancel_addr_reg;
    assign timer_ms          = timer_reg;
    assign notify            = notify_reg;
    assign reason_class      = class_reg;
    assign link_state        = state_reg;
    assign addr_out          = addr_reg;

    // ---------------- checks ----------------
    // an event is held off only while a result waits
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty result register");

    // a retry arm always leaves the link connecting
    a_retry_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && arm_retry_reg) |-> (state_reg == lrbs_pkg::PH_CONNECTING))
        else $error("retry armed outside connecting phase");

    // a reason class is reported only with a disconnect notification
    a_class_with_notify: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && class_reg != lrbs_pkg::CLS_AUTH)
            |-> (notify_reg == lrbs_pkg::NTF_DISCONNECTED))
        else $error("reason class without disconnect notification");

    // a refused connect call has no side effects
    a_status_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != lrbs_pkg::ST_OK)
            |-> (!start_reg && !drop_reg && notify_reg == lrbs_pkg::NTF_NONE))
        else $error("action issued with failed call status");

endmodule
